FILE: design/assert_macros.svh
// Assertion macros used by the combination enumerator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, ignored while reset is high.
`define CE_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define CE_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ce_pkg.sv
// Constants, codes and types shared by the combination enumerator modules.
package ce_pkg;

  localparam int MAX_SET  = 16;
  localparam int MAX_PICK = 8;

  localparam int VALUE_W  = 32;
  localparam int SLOT_W   = 4;
  localparam int POS_W    = 3;
  localparam int N_W      = 5;
  localparam int K_W      = 4;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [N_W-1:0] N_MAX = N_W'(MAX_SET);
  localparam logic [K_W-1:0] K_MAX = K_W'(MAX_PICK);

  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEXT    = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_ELEMENT   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd2;

  // Register select taken from paddr[2].
  localparam logic REG_SET_SIZE     = 1'b0;
  localparam logic REG_CHOOSE_COUNT = 1'b1;

  typedef struct packed {
    logic restart;
    logic advance;
  } ce_idx_ctrl_t;

  typedef struct packed {
    logic found;
    logic exhausted;
  } ce_idx_stat_t;

endpackage

FILE: design/ce_index.sv
// Index vector of the current combination, its successor logic and the exhausted flag.
module ce_index import ce_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ce_idx_ctrl_t       ctrl,
  input  logic [N_W-1:0]     n,
  input  logic [K_W-1:0]     k,
  input  logic [POS_W-1:0]   rd_pos,
  output logic [SLOT_W-1:0]  rd_idx,
  output ce_idx_stat_t       stat
);

  logic [SLOT_W-1:0] idx_vec [MAX_PICK];
  logic              exhausted;
  logic              found;
  logic [POS_W-1:0]  pos;
  logic [SLOT_W-1:0] base;

  // The rightmost position still below its ceiling N-K+i wins, since the scan runs upward.
  always_comb begin
    found = 1'b0;
    pos   = '0;
    base  = '0;
    for (int i = 0; i < MAX_PICK; i++) begin
      if ((K_W'(i) < k) &&
          ({2'b00, idx_vec[i]} < ({1'b0, n} - {2'b00, k} + (N_W+1)'(i)))) begin
        found = 1'b1;
        pos   = POS_W'(i);
        base  = idx_vec[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      for (int i = 0; i < MAX_PICK; i++) begin
        idx_vec[i] <= SLOT_W'(i);
      end
      exhausted <= 1'b0;
    end else if (ctrl.advance) begin
      if (found) begin
        // The raised index and every one after it form a run of consecutive values.
        for (int i = 0; i < MAX_PICK; i++) begin
          if ((POS_W'(i) >= pos) && (K_W'(i) < k)) begin
            idx_vec[i] <= base + SLOT_W'(1) + SLOT_W'(i) - {1'b0, pos};
          end
        end
      end else begin
        exhausted <= 1'b1;
      end
    end
  end

  assign rd_idx          = idx_vec[rd_pos];
  assign stat.found      = found;
  assign stat.exhausted  = exhausted;

endmodule

FILE: design/combination_enumerator.sv
// Top level of the lexicographic K-combination enumerator.
// Load words write one list slot and restart words reset the enumeration; for
// both, busy stays low. A next word with a valid configuration raises busy while
// it makes one list-memory read per cycle, one per element, and the K element
// words come out from the registered read port, one per cycle, with result_valid
// high for each; a new word is taken once busy falls. A next word while exhausted
// or with a bad configuration (K=0, K>N or K above eight) gives a single status
// word in the cycle after it is taken. Results cannot be stalled, and no clearing
// pass follows reset: list slots read before being loaded are undefined.
`include "assert_macros.svh"

module combination_enumerator import ce_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [VALUE_W-1:0]  value,
  output logic                result_valid,
  output logic [VALUE_W-1:0]  element_value,
  output logic [POS_W-1:0]    element_position,
  output logic [SLOT_W-1:0]   source_index,
  output logic                last_of_combination,
  output logic                final_combination,
  output logic [STATUS_W-1:0] status,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                set_size;
  logic [N_W-1:0]      set_size_q;
  logic [K_W-1:0]      choose_count;
  logic [N_W-1:0]      n_sat;
  logic                cfg_bad;
  logic                cfg_write;
  logic                accept;
  logic                state;
  logic [POS_W-1:0]    cnt;
  logic [POS_W-1:0]    k_last;
  logic                run_last;
  logic [SLOT_W-1:0]   rd_idx;
  logic [VALUE_W-1:0]  list_mem [MAX_SET];
  logic [VALUE_W-1:0]  rd_data;
  logic [POS_W-1:0]    pos_q;
  logic [SLOT_W-1:0]   idx_q;
  logic                last_q;
  logic                final_q;
  logic [STATUS_W-1:0] status_q;
  ce_idx_ctrl_t        idx_ctrl;
  ce_idx_stat_t        idx_stat;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign set_size  = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size_q   <= N_MAX;
      choose_count <= K_W'(1);
    end else if (cfg_write) begin
      unique case (set_size)
        REG_SET_SIZE:     set_size_q   <= pwdata[N_W-1:0];
        REG_CHOOSE_COUNT: choose_count <= pwdata[K_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (set_size)
      REG_SET_SIZE:     prdata = DATA_W'(set_size_q);
      REG_CHOOSE_COUNT: prdata = DATA_W'(choose_count);
      default:          prdata = '0;
    endcase
  end

  assign n_sat   = (set_size_q > N_MAX) ? N_MAX : set_size_q;
  assign cfg_bad = (choose_count == '0) || ({1'b0, choose_count} > n_sat) ||
                   (choose_count > K_MAX);
  assign k_last  = POS_W'(choose_count - K_W'(1));

  // Sequencer.
  assign busy     = (state == ST_RUN);
  assign accept   = start && !busy;
  assign run_last = (state == ST_RUN) && (cnt == k_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept && (kind == KIND_NEXT)) begin
            if (cfg_bad || idx_stat.exhausted) begin
              result_valid <= 1'b1;
            end else begin
              state <= ST_RUN;
              cnt   <= '0;
            end
          end
        end
        ST_RUN: begin
          result_valid <= 1'b1;
          if (cnt == k_last) begin
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + POS_W'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Fields registered alongside the list read, so they line up with the read data.
  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      pos_q    <= cnt;
      idx_q    <= rd_idx;
      last_q   <= (cnt == k_last);
      final_q  <= !idx_stat.found;
      status_q <= STATUS_ELEMENT;
    end else if (accept && (kind == KIND_NEXT)) begin
      pos_q    <= '0;
      idx_q    <= '0;
      last_q   <= 1'b1;
      final_q  <= 1'b0;
      status_q <= cfg_bad ? STATUS_INVALID : STATUS_EXHAUSTED;
    end
  end

  // List memory: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && (kind == KIND_LOAD)) begin
      list_mem[slot] <= value;
    end
    rd_data <= list_mem[rd_idx];
  end

  assign idx_ctrl.restart = accept && (kind == KIND_RESTART);
  assign idx_ctrl.advance = run_last;

  ce_index u_index (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (idx_ctrl),
    .n      (n_sat),
    .k      (choose_count),
    .rd_pos (cnt),
    .rd_idx (rd_idx),
    .stat   (idx_stat)
  );

  assign element_value       = (status_q == STATUS_ELEMENT) ? rd_data : '0;
  assign element_position    = pos_q;
  assign source_index        = idx_q;
  assign last_of_combination = last_q;
  assign final_combination   = final_q;
  assign status              = status_q;

  `CE_ASSERT(a_bad_cfg_reports, clk, rst,
    accept && (kind == KIND_NEXT) && cfg_bad |=>
      result_valid && last_of_combination && (status == STATUS_INVALID),
    "next word with a bad configuration did not report invalid")
  `CE_ASSERT(a_run_ends_last, clk, rst,
    run_last |=> result_valid && last_of_combination && (status == STATUS_ELEMENT),
    "final element word of a combination is not marked last")
  `CE_ASSERT(a_exhaust_on_final, clk, rst,
    $rose(idx_stat.exhausted) |-> result_valid && final_combination && last_of_combination,
    "enumeration became exhausted without a final combination")
  `CE_ASSERT_ALWAYS(a_reset_quiet, clk,
    rst |=> !busy && !result_valid,
    "block not quiet after reset")

endmodule
